FILE: src/cbre_pkg.sv
`timescale 1ns / 1ps

package cbre_pkg;

    localparam int RANDOM_WIDTH_DEF = 16;
    localparam int WORD_W           = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int SPAN_W           = 16;

    localparam int TDATA_IN_W   = 24;
    localparam int TDATA_OUT_W  = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTTED  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BATT_EXT = 3'd4;

    localparam logic [3:0] MIN_BE_RESET = 4'd2;
    localparam logic [3:0] MAX_BE_RESET = 4'd5;
    localparam logic [2:0] MAX_BO_RESET = 3'd4;
    localparam logic [3:0] BATT_BE_CAP  = 4'd2;

    localparam logic [7:0] PERIODS_SAT  = 8'd255;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_EXPIRED = 3'd1,
        REQ_CLEAR   = 3'd2,
        REQ_BUSY    = 3'd3,
        REQ_ACK     = 3'd4,
        REQ_TIMEOUT = 3'd5,
        REQ_UNKNOWN = 3'd6
    } req_kind_t;

    typedef enum logic [2:0] {
        ACT_IGNORED  = 3'd0,
        ACT_WAIT     = 3'd1,
        ACT_CCA      = 3'd2,
        ACT_WAIT_ONE = 3'd3,
        ACT_TX       = 3'd4,
        ACT_SUCCESS  = 3'd5,
        ACT_UNACKED  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_BACKOFF  = 2'd1,
        MODE_CCA      = 2'd2,
        MODE_WAIT_ACK = 2'd3
    } mode_t;

    typedef enum logic {
        SEQ_READY = 1'b0,
        SEQ_DRAW  = 1'b1
    } seq_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [2:0]  frame_retries;
        logic        needs_ack;
        logic [WORD_W-1:0] random_word;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  backoff_periods;
        logic [2:0]  retries_left;
        logic [3:0]  backoff_number;
    } result_t;

endpackage

FILE: src/cbre_front.sv
`timescale 1ns / 1ps

module cbre_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic [2:0]          frame_retries,
    input  logic                needs_ack,
    input  logic [cbre_pkg::WORD_W-1:0] random_word,
    output logic                head_valid,
    output cbre_pkg::item_t     head,
    input  logic                pop
);

    localparam int PTR_W = $clog2(cbre_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cbre_pkg::QUEUE_DEPTH + 1);

    cbre_pkg::item_t   queue_reg [cbre_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    cbre_pkg::req_kind_t kind;
    logic              push;
    logic              do_pop;

    // classify the request code
    always_comb begin
        case (req_type)
            cbre_pkg::REQ_START, cbre_pkg::REQ_EXPIRED, cbre_pkg::REQ_CLEAR,
            cbre_pkg::REQ_BUSY, cbre_pkg::REQ_ACK, cbre_pkg::REQ_TIMEOUT: begin
                kind = cbre_pkg::req_kind_t'(req_type);
            end
            default: begin
                kind = cbre_pkg::REQ_UNKNOWN;
            end
        endcase
    end

    // no item is taken while reset is held
    assign in_ready   = aresetn && (count_reg != CNT_W'(cbre_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cbre_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cbre_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{kind: kind, frame_retries: frame_retries,
                                       needs_ack: needs_ack, random_word: random_word};
        end
    end

endmodule

FILE: src/cbre_mod.sv
`timescale 1ns / 1ps

// remainder of dividend by (2^exp - 1), restoring, two bits per cycle
module cbre_mod #(
    parameter int RANDOM_WIDTH = cbre_pkg::RANDOM_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [RANDOM_WIDTH-1:0]   dividend,
    input  logic [3:0]                exp_i,
    output logic                      done,
    output logic [cbre_pkg::SPAN_W-2:0] remainder
);

    localparam int STEPS = (RANDOM_WIDTH + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int SW    = cbre_pkg::SPAN_W;

    logic [PAD_W-1:0] dvd_reg, dvd_next;
    logic [SW-2:0]    rem_reg, rem_next;
    logic [SW-1:0]    span_reg, span_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    t1, t1_r, t2, t2_r;

    always_comb begin
        t1   = {rem_reg, dvd_reg[PAD_W-1]};
        t1_r = (t1 >= span_reg) ? t1 - span_reg : t1;
        t2   = {t1_r[SW-2:0], dvd_reg[PAD_W-2]};
        t2_r = (t2 >= span_reg) ? t2 - span_reg : t2;
    end

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = PAD_W'(dividend);
            rem_next  = '0;
            span_next = (SW'(1) << exp_i) - SW'(1);
            cnt_next  = CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            dvd_next  = {dvd_reg[PAD_W-3:0], 2'b00};
            rem_next  = t2_r[SW-2:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        span_reg <= span_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/cbre_back.sv
`timescale 1ns / 1ps

module cbre_back #(
    parameter int RANDOM_WIDTH = cbre_pkg::RANDOM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cbre_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              head_valid,
    input  cbre_pkg::item_t                   head,
    output logic                              pop,
    output logic                              res_valid,
    input  logic                              res_ready,
    output cbre_pkg::result_t                 res
);

    // configuration
    logic [3:0] min_be_reg, max_be_reg;
    logic [2:0] max_bo_reg;
    logic       slotted_reg, batt_ext_reg;

    // protocol state
    cbre_pkg::mode_t mode_reg, mode_next;
    logic [3:0] busy_reg, busy_next;
    logic [1:0] window_reg, window_next;
    logic [3:0] be_reg, be_next;
    logic [2:0] attempts_reg, attempts_next;
    logic       ack_reg, ack_next;

    cbre_pkg::seq_t  seq_reg, seq_next;
    logic            out_valid_reg, out_valid_next;
    cbre_pkg::result_t out_reg, out_next;

    cbre_pkg::action_t act;
    logic [7:0]  fixed_periods;
    logic        want_draw;
    logic        draw_now;
    logic        out_free;
    logic        div_start;
    logic        div_done;
    logic [cbre_pkg::SPAN_W-2:0] div_rem;
    logic [cbre_pkg::SPAN_W-1:0] draw_len;
    logic [7:0]  draw_sat;
    logic [1:0]  fresh_window;
    logic [3:0]  open_be;
    logic [4:0]  be_inc;

    // writes are taken only out of reset
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_be_reg   <= cbre_pkg::MIN_BE_RESET;
            max_be_reg   <= cbre_pkg::MAX_BE_RESET;
            max_bo_reg   <= cbre_pkg::MAX_BO_RESET;
            slotted_reg  <= 1'b0;
            batt_ext_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbre_pkg::CFG_MIN_BE:   min_be_reg   <= cfg_data[3:0];
                cbre_pkg::CFG_MAX_BE:   max_be_reg   <= cfg_data[3:0];
                cbre_pkg::CFG_MAX_BO:   max_bo_reg   <= cfg_data[2:0];
                cbre_pkg::CFG_SLOTTED:  slotted_reg  <= cfg_data[0];
                cbre_pkg::CFG_BATT_EXT: batt_ext_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign fresh_window = slotted_reg ? 2'd2 : 2'd1;
    assign open_be = (batt_ext_reg && (min_be_reg > cbre_pkg::BATT_BE_CAP))
                   ? cbre_pkg::BATT_BE_CAP : min_be_reg;
    assign be_inc  = {1'b0, be_reg} + 5'd1;

    // one protocol step for the item at the head of the queue
    always_comb begin
        mode_next     = mode_reg;
        busy_next     = busy_reg;
        window_next   = window_reg;
        be_next       = be_reg;
        attempts_next = attempts_reg;
        ack_next      = ack_reg;
        act           = cbre_pkg::ACT_IGNORED;
        fixed_periods = 8'd0;
        want_draw     = 1'b0;
        case (head.kind)
            cbre_pkg::REQ_START: begin
                if (mode_reg == cbre_pkg::MODE_IDLE) begin
                    attempts_next = head.frame_retries;
                    ack_next      = head.needs_ack;
                    mode_next     = cbre_pkg::MODE_BACKOFF;
                    busy_next     = 4'd0;
                    window_next   = fresh_window;
                    be_next       = open_be;
                    want_draw     = 1'b1;
                    act           = cbre_pkg::ACT_WAIT;
                end
            end
            cbre_pkg::REQ_EXPIRED: begin
                if (mode_reg == cbre_pkg::MODE_BACKOFF) begin
                    mode_next = cbre_pkg::MODE_CCA;
                    act       = cbre_pkg::ACT_CCA;
                end
            end
            cbre_pkg::REQ_CLEAR: begin
                if (mode_reg == cbre_pkg::MODE_CCA) begin
                    window_next = window_reg - 2'd1;
                    if (window_next != 2'd0) begin
                        mode_next     = cbre_pkg::MODE_BACKOFF;
                        fixed_periods = 8'd1;
                        act           = cbre_pkg::ACT_WAIT_ONE;
                    end else begin
                        if (attempts_reg != 3'd0) begin
                            attempts_next = attempts_reg - 3'd1;
                        end
                        mode_next = ack_reg ? cbre_pkg::MODE_WAIT_ACK : cbre_pkg::MODE_IDLE;
                        act       = cbre_pkg::ACT_TX;
                    end
                end
            end
            cbre_pkg::REQ_BUSY: begin
                if (mode_reg == cbre_pkg::MODE_CCA) begin
                    window_next = fresh_window;
                    busy_next   = busy_reg + 4'd1;
                    be_next     = (be_inc > {1'b0, max_be_reg}) ? max_be_reg : be_inc[3:0];
                    if ({1'b0, busy_next} > {2'b00, max_bo_reg}) begin
                        if (attempts_reg != 3'd0) begin
                            attempts_next = attempts_reg - 3'd1;
                        end
                        if (attempts_next == 3'd0) begin
                            mode_next = cbre_pkg::MODE_IDLE;
                            act       = cbre_pkg::ACT_UNACKED;
                        end else begin
                            mode_next   = cbre_pkg::MODE_BACKOFF;
                            busy_next   = 4'd0;
                            window_next = fresh_window;
                            be_next     = open_be;
                            want_draw   = 1'b1;
                            act         = cbre_pkg::ACT_WAIT;
                        end
                    end else begin
                        mode_next = cbre_pkg::MODE_BACKOFF;
                        want_draw = 1'b1;
                        act       = cbre_pkg::ACT_WAIT;
                    end
                end
            end
            cbre_pkg::REQ_ACK: begin
                if (mode_reg == cbre_pkg::MODE_WAIT_ACK) begin
                    mode_next = cbre_pkg::MODE_IDLE;
                    act       = cbre_pkg::ACT_SUCCESS;
                end
            end
            cbre_pkg::REQ_TIMEOUT: begin
                if (mode_reg == cbre_pkg::MODE_WAIT_ACK) begin
                    if (attempts_reg == 3'd0) begin
                        mode_next = cbre_pkg::MODE_IDLE;
                        act       = cbre_pkg::ACT_UNACKED;
                    end else begin
                        mode_next   = cbre_pkg::MODE_BACKOFF;
                        busy_next   = 4'd0;
                        window_next = fresh_window;
                        be_next     = open_be;
                        want_draw   = 1'b1;
                        act         = cbre_pkg::ACT_WAIT;
                    end
                end
            end
            default: ;
        endcase
    end

    // exponent zero gives an empty range and a length of zero
    assign draw_now = want_draw && (be_next != 4'd0);
    assign out_free = !out_valid_reg || res_ready;

    // sequencer next state
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            cbre_pkg::SEQ_READY: if (div_start) seq_next = cbre_pkg::SEQ_DRAW;
            cbre_pkg::SEQ_DRAW:  if (div_done)  seq_next = cbre_pkg::SEQ_READY;
            default:             seq_next = cbre_pkg::SEQ_READY;
        endcase
    end

    // sequencer outputs
    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        case (seq_reg)
            cbre_pkg::SEQ_READY: begin
                pop       = head_valid && out_free;
                div_start = head_valid && out_free && draw_now;
            end
            default: ;
        endcase
    end

    assign draw_len = {1'b0, div_rem} + cbre_pkg::SPAN_W'(1);
    assign draw_sat = (draw_len > cbre_pkg::SPAN_W'(cbre_pkg::PERIODS_SAT))
                    ? cbre_pkg::PERIODS_SAT : draw_len[7:0];

    always_comb begin
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (pop) begin
            out_next.action          = act;
            out_next.backoff_periods = fixed_periods;
            out_next.retries_left    = attempts_next;
            out_next.backoff_number  = busy_next;
            if (!draw_now) begin
                out_valid_next = 1'b1;
            end
        end
        if (div_done) begin
            out_next.backoff_periods = draw_sat;
            out_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= cbre_pkg::MODE_IDLE;
            busy_reg      <= 4'd0;
            window_reg    <= 2'd0;
            be_reg        <= 4'd0;
            attempts_reg  <= 3'd0;
            ack_reg       <= 1'b0;
            seq_reg       <= cbre_pkg::SEQ_READY;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg     <= mode_next;
                busy_reg     <= busy_next;
                window_reg   <= window_next;
                be_reg       <= be_next;
                attempts_reg <= attempts_next;
                ack_reg      <= ack_next;
            end
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    cbre_mod #(
        .RANDOM_WIDTH(RANDOM_WIDTH)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (RANDOM_WIDTH'(head.random_word)),
        .exp_i     (be_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: src/csma_ca_backoff_retry_engine.sv
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: retries, ack, random
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: action; tdata: periods, retries, busy
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// an item waits in the two-entry input queue, then passes through the protocol step;
// items that draw a backoff length also pass through the remainder unit, and the next
// item is not taken from the queue until that length is out.
// the input queue keeps accepting while a result waits on m_axis_tready, until it is full.
// reset is synchronous on aresetn low: engine idle, registers at their defaults.
module csma_ca_backoff_retry_engine #(
    parameter int RANDOM_WIDTH = cbre_pkg::RANDOM_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] frame_retries, [3] needs_ack, [19:4] random_word, [23:20] zero
    input  logic [cbre_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] backoff_periods, [10:8] retries_left, [14:11] backoff_number, [15] zero
    output logic [cbre_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    // [2:0] action
    output logic [2:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cbre_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic              head_valid;
    cbre_pkg::item_t   head;
    logic              pop;
    cbre_pkg::result_t res;

    cbre_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (s_axis_tuser),
        .frame_retries (s_axis_tdata[2:0]),
        .needs_ack     (s_axis_tdata[3]),
        .random_word   (s_axis_tdata[19:4]),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop)
    );

    cbre_back #(
        .RANDOM_WIDTH(RANDOM_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tuser = res.action;
    assign m_axis_tdata = {1'b0, res.backoff_number, res.retries_left, res.backoff_periods};

endmodule

FILE: dv/csma_ca_backoff_retry_engine_test.sv
`timescale 1ns / 1ps

module csma_ca_backoff_retry_engine_test;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        cbre_pkg::mode_t mode;
        logic [3:0] busy;
        logic [1:0] window;
        logic [3:0] be;
        logic [2:0] attempts;
        logic       ack_wanted;
    } csma_state_t;

    typedef struct packed {
        logic [3:0] min_be;
        logic [3:0] max_be;
        logic [2:0] max_bo;
        logic       slotted;
        logic       batt_ext;
    } csma_regs_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [cbre_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic [2:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [cbre_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic [2:0]                       m_axis_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [cbre_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cbre_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    csma_regs_t          csma_regs;
    csma_state_t         engine_now;
    csma_state_t         engine_plan;
    cbre_pkg::item_t     pending_events[$];
    cbre_pkg::result_t   outcomes_due[$];
    cbre_pkg::item_t     on_bus;
    int          send_idle_pct = 8;
    int          recv_idle_pct = 56;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    logic        hold_armed = 1'b0;
    logic        hold_taken = 1'b0;

    csma_ca_backoff_retry_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1ns aclk = ~aclk;

    function automatic logic [7:0] backoff_length(logic [3:0] be, logic [15:0] rnd);
        int unsigned span;
        int unsigned len;
        span = (32'd1 << be) - 32'd1;
        if (span == 0)
            return 8'd0;
        len = 32'd1 + (32'(rnd) % span);
        return (len > 32'd255) ? cbre_pkg::PERIODS_SAT : 8'(len);
    endfunction

    function automatic void open_attempt(inout csma_state_t st, input csma_regs_t regs,
                                         input logic [15:0] rnd,
                                         inout cbre_pkg::result_t res);
        st.mode   = cbre_pkg::MODE_BACKOFF;
        st.busy   = 4'd0;
        st.window = regs.slotted ? 2'd2 : 2'd1;
        st.be     = (regs.batt_ext && regs.min_be > cbre_pkg::BATT_BE_CAP)
                  ? cbre_pkg::BATT_BE_CAP : regs.min_be;
        res.action          = cbre_pkg::ACT_WAIT;
        res.backoff_periods = backoff_length(st.be, rnd);
    endfunction

    // out of attempts ends the frame unacked, otherwise a fresh csma attempt
    function automatic void retry_or_give_up(inout csma_state_t st, input csma_regs_t regs,
                                             input logic [15:0] rnd,
                                             inout cbre_pkg::result_t res);
        if (st.attempts == 3'd0) begin
            st.mode    = cbre_pkg::MODE_IDLE;
            res.action = cbre_pkg::ACT_UNACKED;
        end else begin
            open_attempt(st, regs, rnd, res);
        end
    endfunction

    function automatic cbre_pkg::result_t csma_step(inout csma_state_t st,
                                                    input csma_regs_t regs,
                                                    input cbre_pkg::item_t ev);
        cbre_pkg::result_t res;
        logic [4:0]        be_up;
        res = '0;
        res.action = cbre_pkg::ACT_IGNORED;
        case (ev.kind)
            cbre_pkg::REQ_START: begin
                if (st.mode == cbre_pkg::MODE_IDLE) begin
                    st.attempts   = ev.frame_retries;
                    st.ack_wanted = ev.needs_ack;
                    open_attempt(st, regs, ev.random_word, res);
                end
            end
            cbre_pkg::REQ_EXPIRED: begin
                if (st.mode == cbre_pkg::MODE_BACKOFF) begin
                    st.mode    = cbre_pkg::MODE_CCA;
                    res.action = cbre_pkg::ACT_CCA;
                end
            end
            cbre_pkg::REQ_CLEAR: begin
                if (st.mode == cbre_pkg::MODE_CCA) begin
                    st.window = st.window - 2'd1;
                    if (st.window != 2'd0) begin
                        st.mode             = cbre_pkg::MODE_BACKOFF;
                        res.backoff_periods = 8'd1;
                        res.action          = cbre_pkg::ACT_WAIT_ONE;
                    end else begin
                        if (st.attempts != 3'd0)
                            st.attempts = st.attempts - 3'd1;
                        st.mode    = st.ack_wanted ? cbre_pkg::MODE_WAIT_ACK
                                                   : cbre_pkg::MODE_IDLE;
                        res.action = cbre_pkg::ACT_TX;
                    end
                end
            end
            cbre_pkg::REQ_BUSY: begin
                if (st.mode == cbre_pkg::MODE_CCA) begin
                    st.window = regs.slotted ? 2'd2 : 2'd1;
                    st.busy   = st.busy + 4'd1;
                    be_up     = {1'b0, st.be} + 5'd1;
                    st.be     = (be_up > {1'b0, regs.max_be}) ? regs.max_be : be_up[3:0];
                    if (st.busy > {1'b0, regs.max_bo}) begin
                        if (st.attempts != 3'd0)
                            st.attempts = st.attempts - 3'd1;
                        retry_or_give_up(st, regs, ev.random_word, res);
                    end else begin
                        st.mode             = cbre_pkg::MODE_BACKOFF;
                        res.backoff_periods = backoff_length(st.be, ev.random_word);
                        res.action          = cbre_pkg::ACT_WAIT;
                    end
                end
            end
            cbre_pkg::REQ_ACK: begin
                if (st.mode == cbre_pkg::MODE_WAIT_ACK) begin
                    st.mode    = cbre_pkg::MODE_IDLE;
                    res.action = cbre_pkg::ACT_SUCCESS;
                end
            end
            cbre_pkg::REQ_TIMEOUT: begin
                if (st.mode == cbre_pkg::MODE_WAIT_ACK)
                    retry_or_give_up(st, regs, ev.random_word, res);
            end
            default: begin
            end
        endcase
        res.retries_left   = st.attempts;
        res.backoff_number = st.busy;
        return res;
    endfunction

    // sender side: predicts each item as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                outcomes_due.push_back(csma_step(engine_now, csma_regs, on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_events.pop_front();
                    s_axis_tuser  <= on_bus.kind;
                    s_axis_tdata  <= {4'b0000, on_bus.random_word, on_bus.needs_ack,
                                      on_bus.frame_retries};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge aclk) begin
        cbre_pkg::result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got action %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_axis_tuser !== want.action) begin
                        $display("%0t: action expected %0d, got %0d",
                                 $time, want.action, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:0] !== want.backoff_periods) begin
                        $display("%0t: backoff_periods expected %0d, got %0d",
                                 $time, want.backoff_periods, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[10:8] !== want.retries_left) begin
                        $display("%0t: retries_left expected %0d, got %0d",
                                 $time, want.retries_left, m_axis_tdata[10:8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[14:11] !== want.backoff_number) begin
                        $display("%0t: backoff_number expected %0d, got %0d",
                                 $time, want.backoff_number, m_axis_tdata[14:11]);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (hold_armed && !hold_taken) begin
                hold_taken    <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("csma_ca_backoff_retry_engine_test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(logic [cbre_pkg::CFG_INDEX_W-1:0] idx,
                             logic [cbre_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cbre_pkg::CFG_MIN_BE:   csma_regs.min_be   = val;
            cbre_pkg::CFG_MAX_BE:   csma_regs.max_be   = val;
            cbre_pkg::CFG_MAX_BO:   csma_regs.max_bo   = val[2:0];
            cbre_pkg::CFG_SLOTTED:  csma_regs.slotted  = val[0];
            cbre_pkg::CFG_BATT_EXT: csma_regs.batt_ext = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic load_settings(logic [3:0] min_be, logic [3:0] max_be, logic [2:0] max_bo,
                                 logic slotted, logic batt_ext);
        write_reg(cbre_pkg::CFG_MIN_BE, min_be);
        write_reg(cbre_pkg::CFG_MAX_BE, max_be);
        write_reg(cbre_pkg::CFG_MAX_BO, {1'b0, max_bo});
        write_reg(cbre_pkg::CFG_SLOTTED, {3'b000, slotted});
        write_reg(cbre_pkg::CFG_BATT_EXT, {3'b000, batt_ext});
    endtask

    // queues an item and tracks where the engine will be once it is taken
    task automatic push_event(cbre_pkg::req_kind_t kind, logic [2:0] retries, logic ack,
                              logic [15:0] rnd);
        cbre_pkg::item_t ev;
        ev.kind          = kind;
        ev.frame_retries = retries;
        ev.needs_ack     = ack;
        ev.random_word   = rnd;
        pending_events.push_back(ev);
        void'(csma_step(engine_plan, csma_regs, ev));
    endtask

    // mostly legal event flows with random content, the rest arbitrary requests
    task automatic plan_random(int count);
        cbre_pkg::req_kind_t kind;
        logic [15:0]         rnd;
        int                  pick;
        repeat (count) begin
            pick = $urandom_range(9);
            rnd  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff : 16'($urandom);
            if ($urandom_range(99) < 85) begin
                case (engine_plan.mode)
                    cbre_pkg::MODE_IDLE:    kind = cbre_pkg::REQ_START;
                    cbre_pkg::MODE_BACKOFF: kind = cbre_pkg::REQ_EXPIRED;
                    cbre_pkg::MODE_CCA:     kind = ($urandom_range(99) < 60)
                                                 ? cbre_pkg::REQ_CLEAR : cbre_pkg::REQ_BUSY;
                    default:                kind = ($urandom_range(99) < 40)
                                                 ? cbre_pkg::REQ_ACK : cbre_pkg::REQ_TIMEOUT;
                endcase
            end else begin
                kind = cbre_pkg::req_kind_t'(3'($urandom_range(7)));
            end
            push_event(kind, 3'($urandom_range(7)), 1'($urandom_range(1)), rnd);
        end
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        csma_regs = '{min_be: cbre_pkg::MIN_BE_RESET, max_be: cbre_pkg::MAX_BE_RESET,
                      max_bo: cbre_pkg::MAX_BO_RESET, slotted: 1'b0, batt_ext: 1'b0};
        engine_now  = '0;
        engine_plan = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: wrong-mode events, unknown requests, broadcast frame
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_UNKNOWN, 3'd7, 1'b1, 16'hffff);
        push_event(cbre_pkg::req_kind_t'(3'd7), 3'd5, 1'b0, 16'h5a5a);
        push_event(cbre_pkg::REQ_START, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_START, 3'd7, 1'b1, 16'hffff);
        push_event(cbre_pkg::REQ_ACK, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        // one retry, busy once, then the ack never shows up
        push_event(cbre_pkg::REQ_START, 3'd1, 1'b1, 16'hffff);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_BUSY, 3'd0, 1'b0, 16'h8001);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_TIMEOUT, 3'd0, 1'b0, 16'h0000);
        // timeout with budget left retries, then acked
        push_event(cbre_pkg::REQ_START, 3'd7, 1'b1, 16'h1234);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_TIMEOUT, 3'd0, 1'b0, 16'hbeef);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_ACK, 3'd0, 1'b0, 16'h0000);
        settle();

        // min above max, no busy reads allowed, slotted window of two
        load_settings(4'd6, 4'd3, 3'd0, 1'b1, 1'b0);
        push_event(cbre_pkg::REQ_START, 3'd2, 1'b0, 16'h7fff);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_BUSY, 3'd0, 1'b0, 16'h00ff);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_CLEAR, 3'd0, 1'b0, 16'h0000);
        settle();

        // large exponents so the drawn length saturates
        load_settings(4'd12, 4'd15, 3'd1, 1'b0, 1'b0);
        push_event(cbre_pkg::REQ_START, 3'd3, 1'b1, 16'd1000);
        push_event(cbre_pkg::REQ_EXPIRED, 3'd0, 1'b0, 16'h0000);
        push_event(cbre_pkg::REQ_BUSY, 3'd0, 1'b0, 16'd300);
        settle();

        send_idle_pct = 8;
        recv_idle_pct = 56;
        load_settings(4'd0, 4'd0, 3'd7, 1'b0, 1'b0);
        plan_random(600);
        settle();

        send_idle_pct = 56;
        recv_idle_pct = 8;
        load_settings(4'd8, 4'd8, 3'd0, 1'b1, 1'b1);
        plan_random(600);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(4'd5, 4'd2, 3'd2, 1'b0, 1'b1);
        hold_armed = 1'b1;
        plan_random(285);
        settle();

        load_settings(4'd3, 4'd8, 3'd5, 1'b1, 1'b0);
        plan_random(285);
        settle();

        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("csma_ca_backoff_retry_engine_test passed");
        end else begin
            $display("csma_ca_backoff_retry_engine_test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/cbre_pkg.sv
src/cbre_front.sv
src/cbre_mod.sv
src/cbre_back.sv
src/csma_ca_backoff_retry_engine.sv
dv/csma_ca_backoff_retry_engine_test.sv
